### hdl/dmrc_pkg.sv
package dmrc_pkg;

   localparam int COL_W     = 8;
   localparam int ROW_W     = 8;
   localparam int LEN_W     = 9;
   localparam int THR_W     = 24;
   localparam int PROG_W    = 25;
   localparam int HASH_W    = 32;
   localparam int CSR_IDX_W = 1;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_STYLE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRESS = 1'd1;

   // Threshold styles
   localparam logic STYLE_BAYER = 1'b0;
   localparam logic STYLE_HASH  = 1'b1;

   // Hash mixing constants
   localparam logic [HASH_W-1:0] HASH_X_MUL   = 32'd374761393;
   localparam logic [HASH_W-1:0] HASH_Y_MUL   = 32'd668265263;
   localparam logic [HASH_W-1:0] HASH_MIX_MUL = 32'd1274126177;
   localparam int                HASH_SHIFT_A = 13;
   localparam int                HASH_SHIFT_B = 16;

   // 8x8 ordered matrix, indexed by {row[2:0], column[2:0]}
   localparam logic [5:0] BAYER_TABLE [64] = '{
       6'd0, 6'd32,  6'd8, 6'd40,  6'd2, 6'd34, 6'd10, 6'd42,
      6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
      6'd12, 6'd44,  6'd4, 6'd36, 6'd14, 6'd46,  6'd6, 6'd38,
      6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
       6'd3, 6'd35, 6'd11, 6'd43,  6'd1, 6'd33,  6'd9, 6'd41,
      6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
      6'd15, 6'd47,  6'd7, 6'd39, 6'd13, 6'd45,  6'd5, 6'd37,
      6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
   };

   // Controller to datapath
   typedef struct packed {
      logic capture;      // take the accepted cell
      logic hash_mul1;    // first hash product stage
      logic hash_mul2;    // second hash product stage
      logic decide;       // compare threshold against progress
      logic run_update;   // open or restart the run at the cell
      logic load_change;  // load the source-change beat
      logic load_end;     // load the row-end beat
      logic run_close;    // close the open run
   } dmrc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic change_needed;
      logic end_needed;
   } dmrc_status_type;

endpackage

### hdl/dissolve_mask_run_coder_unit.sv
// Dissolve mask run coder. Cells enter in raster order (column, row, end-of-row
// mark), one at a time. Each cell gets a 24-bit threshold, either from the 8x8
// ordered matrix ((2b+1)<<17) or from an integer hash of column and row, and
// shows the new screen when that threshold is below the progress register.
// Runs of equal source are reported as (start, length, source, row, last) beats
// when the source changes and once more at row end, so one cell yields zero, one
// or two beats. An item passes through capture, the first and second hash
// multiplier stages (each registered), the compare, the run update and the
// row-end beat; a stalled result side holds it at the run update or the
// row-end beat. req_stall stays high while a cell is at work. The single
// output register lets the next cell enter while the previous beat still
// waits to be taken. Write style and progress only while no cell is in
// flight; csr_ready is always high.
module dissolve_mask_run_coder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dmrc_pkg::COL_W-1:0]      req_column,
   input  logic [dmrc_pkg::ROW_W-1:0]      req_line_index,
   input  logic                            req_end_of_row,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dmrc_pkg::COL_W-1:0]      rsp_run_head,
   output logic [dmrc_pkg::LEN_W-1:0]      rsp_run_length,
   output logic                            rsp_use_new,
   output logic [dmrc_pkg::ROW_W-1:0]      rsp_run_row,
   output logic                            rsp_last_of_row,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dmrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dmrc_pkg::PROG_W-1:0]     csr_data
);
   import dmrc_pkg::*;

   dmrc_cmd_type    cmd;
   dmrc_status_type status;

   // sequencing: accept, hash, compare, emit
   dmrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // threshold, run state, output beat register and configuration
   dmrc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_column      (req_column),
      .req_line_index  (req_line_index),
      .req_end_of_row  (req_end_of_row),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_run_head    (rsp_run_head),
      .rsp_run_length  (rsp_run_length),
      .rsp_use_new     (rsp_use_new),
      .rsp_run_row     (rsp_run_row),
      .rsp_last_of_row (rsp_last_of_row)
   );

endmodule

### hdl/dmrc_datapath.sv
module dmrc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [dmrc_pkg::COL_W-1:0]        req_column,
   input  logic [dmrc_pkg::ROW_W-1:0]        req_line_index,
   input  logic                              req_end_of_row,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dmrc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dmrc_pkg::PROG_W-1:0]       csr_data,
   input  dmrc_pkg::dmrc_cmd_type            cmd,
   output dmrc_pkg::dmrc_status_type         status,
   output logic [dmrc_pkg::COL_W-1:0]        rsp_run_head,
   output logic [dmrc_pkg::LEN_W-1:0]        rsp_run_length,
   output logic                              rsp_use_new,
   output logic [dmrc_pkg::ROW_W-1:0]        rsp_run_row,
   output logic                              rsp_last_of_row
);
   import dmrc_pkg::*;

   logic                 style_ff;
   logic [PROG_W-1:0]    progress_ff;
   logic [COL_W-1:0]     col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic                 eor_ff;
   logic [HASH_W-1:0]    hash1_ff, hash1_in;
   logic [HASH_W-1:0]    hash2_ff, hash2_in;
   logic                 src_ff, src_in;
   logic                 run_open_ff;
   logic                 run_source_ff;
   logic [COL_W-1:0]     run_first_ff;
   logic [COL_W-1:0]     out_start_ff;
   logic [LEN_W-1:0]     out_len_ff;
   logic                 out_new_ff;
   logic [ROW_W-1:0]     out_row_ff;
   logic                 out_last_ff;

   logic [HASH_W-1:0]    prod_x, prod_y, mix1, mix2;
   logic [THR_W-1:0]     thr_bayer, thr_hash, thr;
   logic [5:0]           bayer_entry;
   logic [LEN_W-1:0]     len_change, len_end;
   logic                 csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff    <= STYLE_BAYER;
         progress_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STYLE:    style_ff    <= csr_data[0];
            CSR_PROGRESS: progress_ff <= csr_data;
            default:      ;
         endcase
      end
   end

   // Hash: two product stages, each registered
   assign prod_x   = {{(HASH_W-COL_W){1'b0}}, col_ff} * HASH_X_MUL;
   assign prod_y   = {{(HASH_W-ROW_W){1'b0}}, row_ff} * HASH_Y_MUL;
   assign hash1_in = prod_x + prod_y;
   assign mix1     = hash1_ff ^ (hash1_ff >> HASH_SHIFT_A);
   assign hash2_in = mix1 * HASH_MIX_MUL;
   assign mix2     = hash2_ff ^ (hash2_ff >> HASH_SHIFT_B);
   assign thr_hash = mix2[THR_W-1:0];

   // (2b+1) << 17
   assign bayer_entry = BAYER_TABLE[{row_ff[2:0], col_ff[2:0]}];
   assign thr_bayer   = {bayer_entry, 1'b1, 17'd0};

   assign thr    = (style_ff == STYLE_HASH) ? thr_hash : thr_bayer;
   assign src_in = ({1'b0, thr} < progress_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff <= req_column;
         row_ff <= req_line_index;
         eor_ff <= req_end_of_row;
      end
      if (cmd.hash_mul1) hash1_ff <= hash1_in;
      if (cmd.hash_mul2) hash2_ff <= hash2_in;
      if (cmd.decide)    src_ff   <= src_in;
   end

   assign status.change_needed = run_open_ff && (src_ff != run_source_ff);
   assign status.end_needed    = eor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff   <= 1'b0;
         run_source_ff <= 1'b0;
         run_first_ff  <= '0;
      end else begin
         if (cmd.run_update) begin
            run_open_ff <= 1'b1;
            if (!run_open_ff || status.change_needed) begin
               run_source_ff <= src_ff;
               run_first_ff  <= col_ff;
            end
         end
         if (cmd.run_close) run_open_ff <= 1'b0;
      end
   end

   // Lengths wrap at nine bits
   assign len_change = {1'b0, col_ff} - {1'b0, run_first_ff};
   assign len_end    = len_change + LEN_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load_change || cmd.load_end) begin
         out_start_ff <= run_first_ff;
         out_len_ff   <= cmd.load_end ? len_end : len_change;
         out_new_ff   <= run_source_ff;
         out_row_ff   <= row_ff;
         out_last_ff  <= cmd.load_end;
      end
   end

   assign rsp_run_head    = out_start_ff;
   assign rsp_run_length  = out_len_ff;
   assign rsp_use_new     = out_new_ff;
   assign rsp_run_row     = out_row_ff;
   assign rsp_last_of_row = out_last_ff;

endmodule

### hdl/dmrc_ctrl.sv
module dmrc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  dmrc_pkg::dmrc_status_type  status,
   output dmrc_pkg::dmrc_cmd_type     cmd
);
   import dmrc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_HASH1  = 3'd1;
   localparam logic [2:0] ST_HASH2  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_RUN    = 3'd4;
   localparam logic [2:0] ST_END    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       load;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_HASH1;
            end
         end
         ST_HASH1: begin
            cmd.hash_mul1 = 1'b1;
            state_in      = ST_HASH2;
         end
         ST_HASH2: begin
            cmd.hash_mul2 = 1'b1;
            state_in      = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_RUN;
         end
         ST_RUN: begin
            // hold until the output register can take the change beat
            if (!status.change_needed || slot_free) begin
               cmd.run_update  = 1'b1;
               cmd.load_change = status.change_needed;
               state_in        = ST_END;
            end
         end
         ST_END: begin
            if (!status.end_needed) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               cmd.load_end  = 1'b1;
               cmd.run_close = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign load = cmd.load_change | cmd.load_end;

   always_comb begin
      priority if (load)          rsp_valid_in = 1'b1;
      else if (!rsp_stall)        rsp_valid_in = 1'b0;
      else                        rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/dmrc_checker.sv
module dmrc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [dmrc_pkg::COL_W-1:0]      rsp_run_head,
   input logic [dmrc_pkg::LEN_W-1:0]      rsp_run_length,
   input logic                            rsp_use_new,
   input logic [dmrc_pkg::ROW_W-1:0]      rsp_run_row,
   input logic                            rsp_last_of_row
);

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_run_head)
         && $stable(rsp_run_length) && $stable(rsp_use_new)
         && $stable(rsp_run_row) && $stable(rsp_last_of_row))
      else $error("stalled rsp beat changed");

   // one cell at a time: busy right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req accepted while previous cell in flight");

   // still busy once the hash stages are done
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##2 req_stall)
      else $error("cell left hash stages early");

   // nothing to show right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("rsp_valid or req_stall high after reset");

endmodule

bind dissolve_mask_run_coder_unit dmrc_checker u_dmrc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_run_head    (rsp_run_head),
   .rsp_run_length  (rsp_run_length),
   .rsp_use_new     (rsp_use_new),
   .rsp_run_row     (rsp_run_row),
   .rsp_last_of_row (rsp_last_of_row)
);

### dv/tb_top.sv
module tb_top;
   import dmrc_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 5;
   // Watchdog limit, set well past the slowest legal run.
   localparam int CYCLE_LIMIT     = 500000;
   // Settle time after draining: covers a cell from acceptance to its last beat, plus margin.
   localparam int SETTLE_CYCLES   = 12;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int HOLDOFF_CYCLES  = 400;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_PHASES   = 8;
   localparam int CELLS_PER_PHASE = 235;

   localparam logic [PROG_W-1:0] PROGRESS_HALF = 25'h0800000;
   localparam logic [PROG_W-1:0] PROGRESS_DONE = 25'h1000000;
   localparam logic [PROG_W-1:0] PROGRESS_MAX  = 25'h1FFFFFF;

   // Hash noise mixing constants, kept apart from the design's copy.
   localparam logic [31:0] NOISE_X_MUL   = 32'd374761393;
   localparam logic [31:0] NOISE_Y_MUL   = 32'd668265263;
   localparam logic [31:0] NOISE_MIX_MUL = 32'd1274126177;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] line_index;
      logic             end_of_row;
   } cell_item_type;

   typedef struct packed {
      logic [COL_W-1:0] run_head;
      logic [LEN_W-1:0] run_length;
      logic             use_new;
      logic [ROW_W-1:0] run_row;
      logic             last_of_row;
   } run_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [COL_W-1:0]     req_column = '0;
   logic [ROW_W-1:0]     req_line_index = '0;
   logic                 req_end_of_row = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COL_W-1:0]     rsp_run_head;
   logic [LEN_W-1:0]     rsp_run_length;
   logic                 rsp_use_new;
   logic [ROW_W-1:0]     rsp_run_row;
   logic                 rsp_last_of_row;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_STYLE;
   logic [PROG_W-1:0]    csr_data = '0;

   cell_item_type pending_cells[$];
   run_beat_type  due_runs[$];

   // Shadow of the coder: registers as last written, plus the open run.
   logic             model_style = STYLE_BAYER;
   logic [PROG_W-1:0] model_progress = '0;
   logic             run_open = 1'b0;
   logic             run_new = 1'b0;
   logic [COL_W-1:0] run_first = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fault_count = 0;
   int cycle_count = 0;
   int holdoff_left = 0;
   logic holdoff_arm = 1'b0;
   logic holdoff_spent = 1'b0;

   run_beat_type seen_beat;
   run_beat_type want_beat;

   dissolve_mask_run_coder_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_column      (req_column),
      .req_line_index  (req_line_index),
      .req_end_of_row  (req_end_of_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_run_head    (rsp_run_head),
      .rsp_run_length  (rsp_run_length),
      .rsp_use_new     (rsp_use_new),
      .rsp_run_row     (rsp_run_row),
      .rsp_last_of_row (rsp_last_of_row),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Threshold of one cell as unsigned Q0.24. The ordered matrix rank is built
   // by bit interleaving: column xor row bits go to the odd places, row bits to
   // the even places, lowest bits first from the top.
   function automatic logic [THR_W-1:0] cell_level(input logic sel,
         input logic [COL_W-1:0] x, input logic [ROW_W-1:0] y);
      logic [31:0] h;
      logic [2:0]  d;
      logic [5:0]  rank;
      if (sel == STYLE_HASH) begin
         h = 32'(x) * NOISE_X_MUL + 32'(y) * NOISE_Y_MUL;
         h = (h ^ (h >> 13)) * NOISE_MIX_MUL;
         h = h ^ (h >> 16);
         return h[THR_W-1:0];
      end
      d = x[2:0] ^ y[2:0];
      rank = {d[0], y[0], d[1], y[1], d[2], y[2]};
      // (2b+1) << 17, i.e. (b + 0.5) / 64
      return {rank, 1'b1, 17'd0};
   endfunction

   // Advance the run state by one accepted cell and queue the beats it causes.
   task automatic code_cell(input cell_item_type item);
      logic             src;
      logic [LEN_W-1:0] span;
      run_beat_type     beat;
      src = PROG_W'(cell_level(model_style, item.column, item.line_index))
            < model_progress;
      if (!run_open) begin
         run_open = 1'b1;
         run_new = src;
         run_first = item.column;
      end else if (src != run_new) begin
         // Source flips: close the open run before this cell, open at this cell.
         span = LEN_W'(item.column) - LEN_W'(run_first);
         beat.run_head = run_first;
         beat.run_length = span;
         beat.use_new = run_new;
         beat.run_row = item.line_index;
         beat.last_of_row = 1'b0;
         due_runs.push_back(beat);
         run_new = src;
         run_first = item.column;
      end
      if (item.end_of_row) begin
         // Row end: flush the open run, including this cell. Lengths wrap at 9 bits.
         span = LEN_W'(item.column) - LEN_W'(run_first) + LEN_W'(1);
         beat.run_head = run_first;
         beat.run_length = span;
         beat.use_new = run_new;
         beat.run_row = item.line_index;
         beat.last_of_row = 1'b1;
         due_runs.push_back(beat);
         run_open = 1'b0;
      end
   endtask

   task automatic note_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("%s", what);
   endtask

   // Register writes belong only to idle times of the coder; neither this task nor the coder enforces it.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [PROG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_STYLE)
         model_style = value[0];
      else
         model_progress = value;
      @(negedge clock);
   endtask

   // Queue one row segment in raster order; close it with an end mark or leave it open.
   task automatic queue_row(input int start, input int width, input logic [ROW_W-1:0] row,
         input logic close);
      cell_item_type item;
      for (int i = 0; i < width; i++) begin
         item.column = COL_W'(start + i);
         item.line_index = row;
         item.end_of_row = close && (i == width - 1);
         pending_cells.push_back(item);
      end
   endtask

   task automatic queue_cell(input int column, input int row, input logic close);
      cell_item_type item;
      item.column = COL_W'(column);
      item.line_index = ROW_W'(row);
      item.end_of_row = close;
      pending_cells.push_back(item);
   endtask

   // Mostly well-formed rows with random content; some rows left without an end
   // mark so the run carries over, and some scattered noise cells.
   task automatic queue_random_cells(input int target);
      int               queued;
      int               start;
      int               width;
      int               roll;
      logic [ROW_W-1:0] row;
      queued = 0;
      row = ROW_W'($urandom);
      while (queued < target) begin
         roll = $urandom_range(0, 99);
         start = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(0, 255);
         if ($urandom_range(0, 99) < 4)
            width = $urandom_range(1, 256 - start);
         else
            width = $urandom_range(1, (256 - start < 24) ? 256 - start : 24);
         if (roll < 80) begin
            queue_row(start, width, row, 1'b1);
         end else if (roll < 90) begin
            queue_row(start, width, row, 1'b0);
         end else begin
            width = $urandom_range(1, 5);
            for (int i = 0; i < width; i++)
               queue_cell($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 3) == 0);
         end
         queued += width;
         row = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom) : row + 1'b1;
      end
   endtask

   // Wait until every cell is taken and every beat has come out, then let the
   // pipeline settle so a cell that yields no beat is out of flight too.
   task automatic drain();
      int waited;
      waited = 0;
      while ((pending_cells.size() != 0 || req_valid || due_runs.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Cell driver: predict on each accepted beat, hold a stalled beat, and offer
   // the next pending cell unless this cycle is picked to idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            code_cell('{req_column, req_line_index, req_end_of_row});
         if (!req_valid || !req_stall) begin
            if (pending_cells.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_column <= pending_cells[0].column;
               req_line_index <= pending_cells[0].line_index;
               req_end_of_row <= pending_cells[0].end_of_row;
               void'(pending_cells.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the coder backs up into its input.
   always @(posedge clock) begin
      if (holdoff_arm && !holdoff_spent) begin
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_spent <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Run monitor: compare each taken beat with the oldest expected run.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            seen_beat = '{rsp_run_head, rsp_run_length, rsp_use_new, rsp_run_row,
                          rsp_last_of_row};
            if (due_runs.size() == 0) begin
               note_fault($sformatf(
                  "unexpected run beat: start %0d len %0d new %0b row %0d last %0b",
                  seen_beat.run_head, seen_beat.run_length, seen_beat.use_new,
                  seen_beat.run_row, seen_beat.last_of_row));
            end else begin
               want_beat = due_runs.pop_front();
               if (seen_beat.run_head != want_beat.run_head
                   || seen_beat.run_length != want_beat.run_length
                   || seen_beat.use_new != want_beat.use_new
                   || seen_beat.run_row != want_beat.run_row
                   || seen_beat.last_of_row != want_beat.last_of_row)
                  note_fault($sformatf({"run beat mismatch: expected start %0d len %0d new %0b",
                     " row %0d last %0b, got start %0d len %0d new %0b row %0d last %0b"},
                     want_beat.run_head, want_beat.run_length, want_beat.use_new,
                     want_beat.run_row, want_beat.last_of_row,
                     seen_beat.run_head, seen_beat.run_length, seen_beat.use_new,
                     seen_beat.run_row, seen_beat.last_of_row));
            end
         end
         rsp_stall <= (holdoff_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic             sel;
      logic [PROG_W-1:0] prog;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Ordered matrix at half progress: row 0 flips source on every cell, a
      // lone cell at the last column and row, a column going backwards, a row
      // change without an end mark, and a repeated column.
      write_csr(CSR_STYLE, PROG_W'(STYLE_BAYER));
      write_csr(CSR_PROGRESS, PROGRESS_HALF);
      queue_row(0, 8, '0, 1'b1);
      queue_cell(255, 255, 1'b1);
      queue_cell(250, 17, 1'b0);
      queue_cell(3, 18, 1'b0);
      queue_cell(3, 18, 1'b1);
      queue_cell(0, 0, 1'b1);
      drain();

      // Hash noise above fully done: every cell new, run up to the last column.
      write_csr(CSR_STYLE, PROG_W'(STYLE_HASH));
      write_csr(CSR_PROGRESS, PROGRESS_MAX);
      queue_row(248, 8, 8'd128, 1'b1);
      drain();

      // Progress zero: every cell old; a run from column 0 to 255 has the longest length.
      write_csr(CSR_PROGRESS, '0);
      queue_cell(0, 255, 1'b0);
      queue_cell(255, 0, 1'b1);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         sel = p[0] ? STYLE_HASH : STYLE_BAYER;
         case (p)
            2:       prog = PROGRESS_DONE;
            3:       prog = '0;
            4:       prog = PROGRESS_MAX;
            // land exactly on a matrix threshold to probe the strict compare
            5:       prog = {1'b0, 6'($urandom), 1'b1, 17'd0};
            7:       prog = PROG_W'($urandom);
            default: prog = PROG_W'($urandom_range(0, PROGRESS_DONE));
         endcase
         write_csr(CSR_STYLE, PROG_W'(sel));
         write_csr(CSR_PROGRESS, prog);
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         queue_random_cells(CELLS_PER_PHASE);
         // first phase runs without idling: hold the receiver off while cells keep coming
         if (p == 0)
            holdoff_arm = 1'b1;
         drain();
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end

      if (due_runs.size() != 0)
         note_fault($sformatf("%0d expected run beats never arrived", due_runs.size()));
      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
